[hdl/phx_pkg.sv]
// ----------------------------------------------------------------------------
// phx_pkg
// Shared types and constants of the Philox counter generator: input action
// codes, configuration register indexes and the controller/datapath links.
// ----------------------------------------------------------------------------
package phx_pkg;

	// Input actions
	localparam logic [1:0] ACT_GENERATE = 2'd0;
	localparam logic [1:0] ACT_WRITE    = 2'd1;
	localparam logic [1:0] ACT_CLEAR    = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_KEY_FIRST    = 3'd0;
	localparam logic [2:0] REG_KEY_SECOND   = 3'd1;
	localparam logic [2:0] REG_MULTIPLIER_A = 3'd2;
	localparam logic [2:0] REG_MULTIPLIER_B = 3'd3;
	localparam logic [2:0] REG_WEYL_A       = 3'd4;
	localparam logic [2:0] REG_WEYL_B       = 3'd5;
	localparam logic [2:0] REG_ROUND_TOTAL  = 3'd6;
	localparam logic [2:0] REG_LANE_MODE    = 3'd7;

	// Reset values of the configuration registers
	localparam logic [31:0] RST_MULTIPLIER_A = 32'hD251_1F53;
	localparam logic [31:0] RST_MULTIPLIER_B = 32'hCD9E_8D57;
	localparam logic [31:0] RST_WEYL_A       = 32'h9E37_79B9;
	localparam logic [31:0] RST_WEYL_B       = 32'hBB67_AE85;
	localparam logic [4:0]  RST_ROUND_TOTAL  = 5'd10;

	// Multiplier slice width; a counter word of up to two slices is multiplied
	// one slice per cycle.
	localparam int MUL_BITS   = 32;
	localparam int MAX_CHUNKS = 2;
	localparam int CHUNK_BITS = 1;

	typedef struct packed {
		logic [31:0] key_first;
		logic [31:0] key_second;
		logic [31:0] multiplier_a;
		logic [31:0] multiplier_b;
		logic [31:0] weyl_a;
		logic [31:0] weyl_b;
		logic [4:0]  round_total;
		logic        lane_mode;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic                  load;   // load round state from counter, bump counter
		logic                  wr;     // write one counter word
		logic                  clr;    // clear the counter
		logic                  mul;    // accumulate one multiplier slice
		logic                  mix;    // last slice: finish products and apply round
		logic [CHUNK_BITS-1:0] chunk;  // multiplier slice in work
		logic                  emit;   // load one block word into the output register
		logic [1:0]            pos;
		logic                  last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

[hdl/phx_if.sv]
// ----------------------------------------------------------------------------
// phx_if
// Valid/ready channels of the Philox generator: request and result words.
// ----------------------------------------------------------------------------
interface phx_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  word_index;
	logic [31:0] word_value;

	modport source (output valid, action, word_index, word_value, input ready);
	modport sink   (input valid, action, word_index, word_value, output ready);
endinterface

interface phx_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;
	logic [1:0]  position;
	logic        last_word;

	modport source (output valid, random_word, position, last_word, input ready);
	modport sink   (input valid, random_word, position, last_word, output ready);
endinterface

[hdl/phx_ctrl.sv]
// ----------------------------------------------------------------------------
// phx_ctrl
// Sequencer of the generator: takes requests, steps the rounds slice by
// slice and walks the block words out to the output register.
// ----------------------------------------------------------------------------
module phx_ctrl #(
	parameter int WORD_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      action,
	output logic            in_ready,
	input  phx_pkg::cfg_t   cfg,
	input  phx_pkg::sts_t   sts,
	output phx_pkg::cmd_t   cmd
);

	localparam int NCHUNK = (WORD_BITS + phx_pkg::MUL_BITS - 1) / phx_pkg::MUL_BITS;
	localparam logic [phx_pkg::CHUNK_BITS-1:0] LAST_CHUNK = phx_pkg::CHUNK_BITS'(NCHUNK - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ROUND = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t                        state_q, state_d;
	logic [4:0]                    rnd_q, rnd_d;
	logic [phx_pkg::CHUNK_BITS-1:0] chunk_q, chunk_d;
	logic [1:0]                    pos_q, pos_d;
	logic [1:0]                    last_pos;
	logic                          accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign last_pos = cfg.lane_mode ? 2'd3 : 2'd1;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		rnd_d     = rnd_q;
		chunk_d   = chunk_q;
		pos_d     = pos_q;
		cmd       = '0;
		cmd.chunk = chunk_q;
		cmd.pos   = pos_q;
		cmd.last  = (pos_q == last_pos);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action)
						phx_pkg::ACT_GENERATE: begin
							cmd.load = 1'b1;
							rnd_d    = '0;
							chunk_d  = '0;
							pos_d    = '0;
							state_d  = (cfg.round_total == 5'd0) ? ST_EMIT : ST_ROUND;
						end
						phx_pkg::ACT_WRITE: cmd.wr  = 1'b1;
						phx_pkg::ACT_CLEAR: cmd.clr = 1'b1;
						default: ;
					endcase
				end
			end
			ST_ROUND: begin
				if (chunk_q != LAST_CHUNK) begin
					cmd.mul = 1'b1;
					chunk_d = chunk_q + 1'b1;
				end else begin
					cmd.mix = 1'b1;
					chunk_d = '0;
					rnd_d   = rnd_q + 5'd1;
					if (rnd_q == cfg.round_total - 5'd1)
						state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					pos_d    = pos_q + 2'd1;
					if (cmd.last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			chunk_q <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
			chunk_q <= chunk_d;
			pos_q   <= pos_d;
		end
	end

endmodule

[hdl/phx_dp.sv]
// ----------------------------------------------------------------------------
// phx_dp
// Datapath of the generator: counter words, round state, the shared
// multiplier pair with slice accumulators, and the output register.
// ----------------------------------------------------------------------------
module phx_dp #(
	parameter int WORD_BITS     = 32,
	parameter int COUNTER_WORDS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  phx_pkg::cfg_t      cfg,
	input  phx_pkg::cmd_t      cmd,
	output phx_pkg::sts_t      sts,
	input  logic [1:0]         word_index,
	input  logic [31:0]        word_value,
	phx_out_if.source          out_ch
);

	localparam int MW    = (WORD_BITS < phx_pkg::MUL_BITS) ? WORD_BITS : phx_pkg::MUL_BITS;
	localparam int PW    = 2 * WORD_BITS;
	localparam int PADW  = phx_pkg::MAX_CHUNKS * phx_pkg::MUL_BITS;
	localparam int USED4 = (COUNTER_WORDS < 4) ? COUNTER_WORDS : 4;
	localparam int USED2 = (COUNTER_WORDS < 2) ? COUNTER_WORDS : 2;

	logic [WORD_BITS-1:0] cnt_q [4];
	logic [WORD_BITS-1:0] cnt_inc [4];
	logic [WORD_BITS-1:0] r0_q, l0_q, r1_q, l1_q, k0_q, k1_q;
	logic [PW-1:0]        acc_a_q, acc_b_q;
	logic [PADW-1:0]      pad_a, pad_b;
	logic [phx_pkg::MUL_BITS-1:0] part_a, part_b;
	logic [phx_pkg::MUL_BITS+MW-1:0] prod_a, prod_b;
	logic [PW-1:0]        full_a, full_b;
	logic [WORD_BITS-1:0] hi_a, lo_a, hi_b, lo_b;
	logic [WORD_BITS-1:0] blk_word;
	logic [2:0]           used_w;
	logic                 carry;
	logic                 ovalid_q;
	logic [31:0]          oword_q;
	logic [1:0]           opos_q;
	logic                 olast_q;

	// Multiplier slices: pair A on r0, pair B on r1
	assign pad_a  = PADW'(r0_q);
	assign pad_b  = PADW'(r1_q);
	assign part_a = pad_a[cmd.chunk * phx_pkg::MUL_BITS +: phx_pkg::MUL_BITS];
	assign part_b = pad_b[cmd.chunk * phx_pkg::MUL_BITS +: phx_pkg::MUL_BITS];
	assign prod_a = part_a * cfg.multiplier_a[MW-1:0];
	assign prod_b = part_b * cfg.multiplier_b[MW-1:0];

	// Accumulate the slice products; the first slice starts from zero
	always_comb begin
		full_a = ((cmd.chunk == '0) ? '0 : acc_a_q)
			+ (PW'(prod_a) << (cmd.chunk * phx_pkg::MUL_BITS));
		full_b = ((cmd.chunk == '0) ? '0 : acc_b_q)
			+ (PW'(prod_b) << (cmd.chunk * phx_pkg::MUL_BITS));
	end

	assign hi_a = full_a[PW-1:WORD_BITS];
	assign lo_a = full_a[WORD_BITS-1:0];
	assign hi_b = full_b[PW-1:WORD_BITS];
	assign lo_b = full_b[WORD_BITS-1:0];

	// Counter increment with carry over the words in use
	assign used_w = cfg.lane_mode ? 3'(USED4) : 3'(USED2);
	always_comb begin
		carry = 1'b1;
		for (int i = 0; i < 4; i++) begin
			cnt_inc[i] = (carry && (3'(i) < used_w)) ? cnt_q[i] + 1'b1 : cnt_q[i];
			carry      = carry && (cnt_q[i] == '1);
		end
	end

	// Counter words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				cnt_q[i] <= '0;
		end else if (cmd.clr) begin
			for (int i = 0; i < 4; i++)
				cnt_q[i] <= '0;
		end else if (cmd.wr) begin
			cnt_q[word_index] <= WORD_BITS'(word_value);
		end else if (cmd.load) begin
			cnt_q <= cnt_inc;
		end
	end

	// Round state and keys
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r0_q <= cnt_q[0];
			l0_q <= cnt_q[1];
			r1_q <= cnt_q[2];
			l1_q <= cnt_q[3];
			k0_q <= WORD_BITS'(cfg.key_first);
			k1_q <= WORD_BITS'(cfg.key_second);
		end else if (cmd.mul) begin
			acc_a_q <= full_a;
			acc_b_q <= full_b;
		end else if (cmd.mix) begin
			k0_q <= k0_q + WORD_BITS'(cfg.weyl_a);
			if (cfg.lane_mode) begin
				r0_q <= hi_b ^ l0_q ^ k0_q;
				l0_q <= lo_b;
				r1_q <= hi_a ^ l1_q ^ k1_q;
				l1_q <= lo_a;
				k1_q <= k1_q + WORD_BITS'(cfg.weyl_b);
			end else begin
				r0_q <= hi_a ^ k0_q ^ l0_q;
				l0_q <= lo_a;
			end
		end
	end

	// Block word selection
	always_comb begin
		unique case (cmd.pos)
			2'd0: blk_word = r0_q;
			2'd1: blk_word = l0_q;
			2'd2: blk_word = r1_q;
			default: blk_word = l1_q;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.emit)
			ovalid_q <= 1'b1;
		else if (out_ch.ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			oword_q <= 32'(blk_word);
			opos_q  <= cmd.pos;
			olast_q <= cmd.last;
		end
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.random_word = oword_q;
	assign out_ch.position    = opos_q;
	assign out_ch.last_word   = olast_q;
	assign sts.out_free       = !ovalid_q || out_ch.ready;

endmodule

[hdl/philox_counter_rng.sv]
// ----------------------------------------------------------------------------
// philox_counter_rng
// Counter-based Philox generator with configurable rounds and block width.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch: generate a block, write one counter word, or
// clear the counter. Write and clear act when taken and return nothing.
// A generate request loads the counter into the round state and bumps the
// counter in the same cycle, runs round_total rounds, then sends the block
// on out_ch one word per transfer (four words, or two in two-word mode),
// with position and last_word marking the word in the block.
// Each round runs slice by slice on the single 32-bit multiplier pair.
// The last word sits in the output register while the next request is
// taken. A stalled out_ch holds the emitted word and pauses the emission;
// in_ch stays closed until the last word is in the output register.
// Configuration is written on cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset clears the counter and the output register and restores the
// register defaults.
// ----------------------------------------------------------------------------
module philox_counter_rng #(
	parameter int WORD_BITS     = 32,
	parameter int COUNTER_WORDS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	phx_in_if.sink      in_ch,
	phx_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	phx_pkg::cfg_t cfg_q;
	phx_pkg::cmd_t cmd;
	phx_pkg::sts_t sts;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_first    <= '0;
			cfg_q.key_second   <= '0;
			cfg_q.multiplier_a <= phx_pkg::RST_MULTIPLIER_A;
			cfg_q.multiplier_b <= phx_pkg::RST_MULTIPLIER_B;
			cfg_q.weyl_a       <= phx_pkg::RST_WEYL_A;
			cfg_q.weyl_b       <= phx_pkg::RST_WEYL_B;
			cfg_q.round_total  <= phx_pkg::RST_ROUND_TOTAL;
			cfg_q.lane_mode    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				phx_pkg::REG_KEY_FIRST:    cfg_q.key_first    <= cfg_data;
				phx_pkg::REG_KEY_SECOND:   cfg_q.key_second   <= cfg_data;
				phx_pkg::REG_MULTIPLIER_A: cfg_q.multiplier_a <= cfg_data;
				phx_pkg::REG_MULTIPLIER_B: cfg_q.multiplier_b <= cfg_data;
				phx_pkg::REG_WEYL_A:       cfg_q.weyl_a       <= cfg_data;
				phx_pkg::REG_WEYL_B:       cfg_q.weyl_b       <= cfg_data;
				phx_pkg::REG_ROUND_TOTAL:  cfg_q.round_total  <= cfg_data[4:0];
				phx_pkg::REG_LANE_MODE:    cfg_q.lane_mode    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	phx_ctrl #(
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.action   (in_ch.action),
		.in_ready (in_ch.ready),
		.cfg      (cfg_q),
		.sts      (sts),
		.cmd      (cmd)
	);

	phx_dp #(
		.WORD_BITS     (WORD_BITS),
		.COUNTER_WORDS (COUNTER_WORDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.sts        (sts),
		.word_index (in_ch.word_index),
		.word_value (in_ch.word_value),
		.out_ch     (out_ch)
	);

	// An emitted word shows up on the output next cycle
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_ch.valid)
		else $error("emitted word not presented");

	// A held word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |-> !cmd.emit)
		else $error("output word overwritten while stalled");

	// After the last word of a block the request channel opens again
	a_last_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> in_ch.ready)
		else $error("request channel not reopened after block");

	// No round work while requests are taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !(cmd.mix || cmd.mul || cmd.emit))
		else $error("datapath busy while idle");

endmodule
